// File: rtl/core/sae_pkg.sv
package sae_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // command codes
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_INSERT = 3'd3;
  localparam logic [2:0] CMD_SORTUP = 3'd4;
  localparam logic [2:0] CMD_SORTDN = 3'd5;
  localparam logic [2:0] CMD_COUNT  = 3'd6;
  localparam logic [2:0] CMD_DUMP   = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_ROTATE = 2'd2;
  localparam logic [1:0] CELL_SORT   = 2'd3;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [6:0]         count;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [CNT_W-1:0] at;
    logic [CNT_W-1:0] count;
    logic             phase;
    logic             desc;
    word_t            value;
  } cell_ctl_t;

endpackage

// File: rtl/core/sae_cell.sv
module sae_cell (
  input  logic                    clk,
  input  logic [sae_pkg::IDX_W-1:0] idx,
  input  sae_pkg::cell_ctl_t      ctl,
  input  sae_pkg::word_t          left_val,
  input  sae_pkg::word_t          right_val,
  output sae_pkg::word_t          val
);

  sae_pkg::word_t           val_r;
  sae_pkg::word_t           val_nxt;
  logic [sae_pkg::CNT_W-1:0] idx_w;
  logic                     pair_left;
  logic                     pair_right;
  logic                     swap_left;
  logic                     swap_right;

  assign idx_w = sae_pkg::CNT_W'(idx);

  // odd-even transposition: this cell is the lower or upper member of a pair
  assign pair_left  = (idx[0] == ctl.phase) &&
                      ((idx_w + sae_pkg::CNT_W'(1)) < ctl.count);
  assign pair_right = (idx[0] != ctl.phase) && (idx_w != '0) && (idx_w < ctl.count);
  assign swap_left  = ctl.desc ? (right_val > val_r) : (val_r > right_val);
  assign swap_right = ctl.desc ? (val_r > left_val) : (left_val > val_r);

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      sae_pkg::CELL_INSERT: begin
        if (idx_w > ctl.at) begin
          val_nxt = left_val;
        end else if (idx_w == ctl.at) begin
          val_nxt = ctl.value;
        end
      end
      sae_pkg::CELL_ROTATE: begin
        val_nxt = right_val;
      end
      sae_pkg::CELL_SORT: begin
        if (pair_left && swap_left) begin
          val_nxt = right_val;
        end else if (pair_right && swap_right) begin
          val_nxt = left_val;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: rtl/core/sortable_array_engine.sv
// Append, remove, insert, count and error results: one command per cycle while the result slot
// is free, result registered in the cycle after acceptance. Sort: CAPACITY (64) odd-even
// compare-exchange rounds in the cell chain, result after the last round. Read and dump: the
// chain rotates CAPACITY (64) steps, one element per unstalled cycle leaving cell 0, and a new
// command is taken after the last step. Reset (rst_n low, synchronous) clears the element count,
// state and output valid; the element cells are not cleared and hold no meaning until written.
module sortable_array_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sae_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sae_pkg::out_item_t out_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SORT   = 2'd1;
  localparam logic [1:0] S_ROTATE = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [sae_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [sae_pkg::IDX_W-1:0] step_r, step_nxt;
  logic                      desc_r, desc_nxt;
  logic                      dump_r, dump_nxt;
  logic [5:0]                pos_r, pos_nxt;
  logic                      out_valid_r, out_valid_nxt;
  sae_pkg::out_item_t        out_r, out_nxt;

  sae_pkg::cell_ctl_t        ctl;
  sae_pkg::word_t            cell_val [sae_pkg::CAPACITY];

  logic                      out_free;
  logic                      accept;
  logic                      full;
  logic [6:0]                pos_p1;
  logic [sae_pkg::CNT_W-1:0] ins_at;
  logic                      emit_req;
  logic                      last_step;
  logic                      load_out;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign full      = (count_r == sae_pkg::CNT_W'(sae_pkg::CAPACITY));
  assign pos_p1    = 7'(in_data.position) + 7'd1;
  assign ins_at    = (pos_p1 > 7'(count_r)) ? count_r : sae_pkg::CNT_W'(pos_p1);
  assign last_step = (step_r == sae_pkg::IDX_W'(sae_pkg::CAPACITY - 1));
  assign emit_req  = dump_r ? (sae_pkg::CNT_W'(step_r) < count_r)
                            : (7'(step_r) == 7'(pos_r));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    desc_nxt      = desc_r;
    dump_nxt      = dump_r;
    pos_nxt       = pos_r;
    load_out      = 1'b0;
    out_nxt       = out_r;
    ctl.op        = sae_pkg::CELL_HOLD;
    ctl.at        = ins_at;
    ctl.count     = count_r;
    ctl.phase     = step_r[0];
    ctl.desc      = desc_r;
    ctl.value     = sae_pkg::word_t'(in_data.value);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.data   = '0;
          out_nxt.count  = 7'(count_r);
          out_nxt.status = sae_pkg::ST_OK;
          out_nxt.last   = 1'b1;
          step_nxt       = '0;
          pos_nxt        = in_data.position;
          case (in_data.command)
            sae_pkg::CMD_APPEND, sae_pkg::CMD_INSERT: begin
              load_out = 1'b1;
              if (full) begin
                out_nxt.status = sae_pkg::ST_ERR;
              end else begin
                ctl.op        = sae_pkg::CELL_INSERT;
                ctl.at        = (in_data.command == sae_pkg::CMD_APPEND) ? count_r : ins_at;
                count_nxt     = count_r + sae_pkg::CNT_W'(1);
                out_nxt.count = 7'(count_nxt);
              end
            end
            sae_pkg::CMD_REMOVE: begin
              load_out = 1'b1;
              if (count_r == '0) begin
                out_nxt.status = sae_pkg::ST_ERR;
              end else begin
                count_nxt     = count_r - sae_pkg::CNT_W'(1);
                out_nxt.count = 7'(count_nxt);
              end
            end
            sae_pkg::CMD_READ: begin
              if (7'(in_data.position) >= 7'(count_r)) begin
                load_out       = 1'b1;
                out_nxt.status = sae_pkg::ST_ERR;
              end else begin
                dump_nxt  = 1'b0;
                state_nxt = S_ROTATE;
              end
            end
            sae_pkg::CMD_SORTUP, sae_pkg::CMD_SORTDN: begin
              desc_nxt  = (in_data.command == sae_pkg::CMD_SORTDN);
              state_nxt = S_SORT;
            end
            sae_pkg::CMD_COUNT: begin
              load_out = 1'b1;
            end
            default: begin
              if (count_r == '0) begin
                load_out       = 1'b1;
                out_nxt.status = sae_pkg::ST_EMPTY;
              end else begin
                dump_nxt  = 1'b1;
                state_nxt = S_ROTATE;
              end
            end
          endcase
        end
      end
      S_SORT: begin
        // hold the final round until the result slot can take the status
        if (!last_step || out_free) begin
          ctl.op   = sae_pkg::CELL_SORT;
          step_nxt = step_r + sae_pkg::IDX_W'(1);
          if (last_step) begin
            load_out       = 1'b1;
            out_nxt.data   = '0;
            out_nxt.count  = 7'(count_r);
            out_nxt.status = sae_pkg::ST_OK;
            out_nxt.last   = 1'b1;
            step_nxt       = '0;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_ROTATE: begin
        // advance the ring only when an emitted element has somewhere to go
        if (!emit_req || out_free) begin
          ctl.op   = sae_pkg::CELL_ROTATE;
          step_nxt = step_r + sae_pkg::IDX_W'(1);
          if (emit_req) begin
            load_out       = 1'b1;
            out_nxt.data   = 32'(cell_val[0]);
            out_nxt.count  = 7'(count_r);
            out_nxt.status = sae_pkg::ST_OK;
            out_nxt.last   = dump_r ? ((sae_pkg::CNT_W'(step_r) + sae_pkg::CNT_W'(1)) == count_r)
                                    : 1'b1;
          end
          if (last_step) begin
            step_nxt  = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  for (genvar g = 0; g < sae_pkg::CAPACITY; g++) begin : g_cell
    sae_cell u_cell (
      .clk       (clk),
      .idx       (sae_pkg::IDX_W'(g)),
      .ctl       (ctl),
      .left_val  (cell_val[(g + sae_pkg::CAPACITY - 1) % sae_pkg::CAPACITY]),
      .right_val (cell_val[(g + 1) % sae_pkg::CAPACITY]),
      .val       (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    dump_r <= dump_nxt;
    pos_r  <= pos_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GEN_GROW   = 0;
  localparam int GEN_SHRINK = 1;
  localparam int GEN_MIXED  = 2;
  localparam int RANDOM_ITEMS = 350;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  sae_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sae_pkg::out_item_t out_data;

  sortable_array_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // commands waiting to be offered, and results the array should produce
  sae_pkg::in_item_t  queued_commands[$];
  sae_pkg::out_item_t pending_results[$];

  sae_pkg::word_t array_model[sae_pkg::CAPACITY];
  int    model_count = 0;
  int    gen_count = 0;
  int    commands_total = 0;
  int    commands_accepted = 0;
  int    results_seen = 0;
  int    mismatches = 0;
  int    cyc = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  logic  quiet;
  logic  hold_on;

  assign quiet   = (cyc >= 2000) && (cyc < 4000);
  assign hold_on = (hold_left != 0);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic sort_model(input bit descending);
    sae_pkg::word_t key;
    int    j;
    for (int i = 1; i < model_count; i++) begin
      key = array_model[i];
      j = i;
      while (j > 0 && (descending ? (key > array_model[j-1]) : (array_model[j-1] > key))) begin
        array_model[j] = array_model[j-1];
        j--;
      end
      array_model[j] = key;
    end
  endtask

  task automatic apply_command(input sae_pkg::in_item_t cmd);
    sae_pkg::out_item_t res;
    int        at;
    res = '0;
    res.last = 1'b1;
    res.status = sae_pkg::ST_OK;
    case (cmd.command)
      sae_pkg::CMD_APPEND: begin
        if (model_count >= sae_pkg::CAPACITY) begin
          res.status = sae_pkg::ST_ERR;
        end else begin
          array_model[model_count] = sae_pkg::word_t'(cmd.value);
          model_count++;
        end
      end
      sae_pkg::CMD_REMOVE: begin
        if (model_count == 0) res.status = sae_pkg::ST_ERR;
        else model_count--;
      end
      sae_pkg::CMD_READ: begin
        if (int'(cmd.position) >= model_count) res.status = sae_pkg::ST_ERR;
        else res.data = array_model[cmd.position];
      end
      sae_pkg::CMD_INSERT: begin
        if (model_count >= sae_pkg::CAPACITY) begin
          res.status = sae_pkg::ST_ERR;
        end else begin
          at = int'(cmd.position) + 1;
          if (at > model_count) at = model_count;
          for (int i = model_count; i > at; i--) array_model[i] = array_model[i-1];
          array_model[at] = sae_pkg::word_t'(cmd.value);
          model_count++;
        end
      end
      sae_pkg::CMD_SORTUP: sort_model(1'b0);
      sae_pkg::CMD_SORTDN: sort_model(1'b1);
      sae_pkg::CMD_COUNT: ;
      sae_pkg::CMD_DUMP: begin
        if (model_count == 0) begin
          res.status = sae_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < model_count; i++) begin
            res.data  = array_model[i];
            res.count = 7'(model_count);
            res.last  = (i == model_count - 1);
            pending_results.insert(pending_results.size(), res);
          end
          return;
        end
      end
      default: ;
    endcase
    res.count = 7'(model_count);
    pending_results.insert(pending_results.size(), res);
  endtask

  task automatic check_result(input sae_pkg::out_item_t got);
    sae_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result data=%0d count=%0d status=%0d last=%0d",
                                got.data, got.count, got.status, got.last));
      return;
    end
    want = pending_results.pop_front();
    if (got.data !== want.data)
      report_mismatch($sformatf("data %0d, want %0d", got.data, want.data));
    if (got.count !== want.count)
      report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
  endtask

  // driver: hold the payload while stalled, advance after each transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(in_data);
        commands_accepted <= commands_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (queued_commands.size() != 0 && (quiet || $urandom_range(0, 99) >= 32)) begin
          in_data  <= queued_commands.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        results_seen <= results_seen + 1;
      end
      out_stall <= hold_on || (!quiet && $urandom_range(0, 99) < 32);
    end
  end

  // one long hold-off on the result side so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 100) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  task automatic push_cmd(input logic [2:0] command, input logic [5:0] position,
                          input logic [31:0] value);
    sae_pkg::in_item_t it;
    it.command  = command;
    it.position = position;
    it.value    = value;
    queued_commands.insert(queued_commands.size(), it);
    commands_total++;
    if ((command == sae_pkg::CMD_APPEND || command == sae_pkg::CMD_INSERT) &&
        gen_count < sae_pkg::CAPACITY) gen_count++;
    if (command == sae_pkg::CMD_REMOVE && gen_count > 0) gen_count--;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4, 5: return 32'($signed($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] rand_position();
    if (gen_count > 0 && $urandom_range(0, 1) == 1)
      return 6'($urandom_range(0, (gen_count > 64 ? 64 : gen_count) - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [2:0] pick_command(input int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      GEN_GROW: begin
        if (r < 40) return sae_pkg::CMD_APPEND;
        if (r < 65) return sae_pkg::CMD_INSERT;
        if (r < 75) return sae_pkg::CMD_READ;
        if (r < 80) return sae_pkg::CMD_REMOVE;
        if (r < 85) return sae_pkg::CMD_SORTUP;
        if (r < 90) return sae_pkg::CMD_SORTDN;
        if (r < 94) return sae_pkg::CMD_COUNT;
        return sae_pkg::CMD_DUMP;
      end
      GEN_SHRINK: begin
        if (r < 10) return sae_pkg::CMD_APPEND;
        if (r < 15) return sae_pkg::CMD_INSERT;
        if (r < 30) return sae_pkg::CMD_READ;
        if (r < 60) return sae_pkg::CMD_REMOVE;
        if (r < 67) return sae_pkg::CMD_SORTUP;
        if (r < 74) return sae_pkg::CMD_SORTDN;
        if (r < 84) return sae_pkg::CMD_COUNT;
        return sae_pkg::CMD_DUMP;
      end
      default: begin
        if (r < 22) return sae_pkg::CMD_APPEND;
        if (r < 36) return sae_pkg::CMD_INSERT;
        if (r < 52) return sae_pkg::CMD_READ;
        if (r < 70) return sae_pkg::CMD_REMOVE;
        if (r < 78) return sae_pkg::CMD_SORTUP;
        if (r < 86) return sae_pkg::CMD_SORTDN;
        if (r < 92) return sae_pkg::CMD_COUNT;
        return sae_pkg::CMD_DUMP;
      end
    endcase
  endfunction

  task automatic push_random(input logic [2:0] command);
    push_cmd(command, rand_position(), rand_word());
  endtask

  initial begin
    int blk;
    int random_start;
    int mode;

    // directed: empty-array corner cases first
    push_cmd(sae_pkg::CMD_COUNT,  6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_REMOVE, 6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_READ,   6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_DUMP,   6'd63, 32'hffff_ffff);
    push_cmd(sae_pkg::CMD_SORTUP, 6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_SORTDN, 6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_APPEND, 6'd63, 32'h7fff_ffff);
    push_cmd(sae_pkg::CMD_APPEND, 6'd0,  32'h8000_0000);
    push_cmd(sae_pkg::CMD_APPEND, 6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_APPEND, 6'd0,  32'hffff_ffff);
    push_cmd(sae_pkg::CMD_INSERT, 6'd0,  32'd5);
    // insert far past the end appends
    push_cmd(sae_pkg::CMD_INSERT, 6'd63, 32'hffff_fffb);
    push_cmd(sae_pkg::CMD_INSERT, 6'd2,  32'h1234_5678);
    push_cmd(sae_pkg::CMD_READ,   6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_READ,   6'd63, 32'h0);
    push_cmd(sae_pkg::CMD_READ,   6'd6,  32'h0);
    push_cmd(sae_pkg::CMD_READ,   6'd7,  32'h0);
    push_cmd(sae_pkg::CMD_SORTUP, 6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_DUMP,   6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_SORTDN, 6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_DUMP,   6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_REMOVE, 6'd0,  32'h0);
    push_cmd(sae_pkg::CMD_COUNT,  6'h2a, 32'h5555_aaaa);
    push_cmd(sae_pkg::CMD_READ,   6'h15, 32'haaaa_5555);

    random_start = commands_total;
    blk = 0;
    while (commands_total - random_start < RANDOM_ITEMS) begin
      if (blk == 3 || blk == 9) begin
        // fill to capacity, then hit the full-array errors
        while (gen_count < sae_pkg::CAPACITY)
          push_random($urandom_range(0, 1) ? sae_pkg::CMD_APPEND : sae_pkg::CMD_INSERT);
        push_random(sae_pkg::CMD_APPEND);
        push_random(sae_pkg::CMD_INSERT);
        push_random(sae_pkg::CMD_SORTUP);
        push_random(sae_pkg::CMD_DUMP);
        push_random(sae_pkg::CMD_READ);
        push_cmd(sae_pkg::CMD_READ, 6'd63, rand_word());
        push_random(sae_pkg::CMD_SORTDN);
        push_random(sae_pkg::CMD_DUMP);
      end else if (blk == 6) begin
        // drain to empty
        while (gen_count > 0)
          push_random($urandom_range(0, 3) == 0 ? sae_pkg::CMD_READ : sae_pkg::CMD_REMOVE);
        push_random(sae_pkg::CMD_REMOVE);
        push_random(sae_pkg::CMD_DUMP);
        push_random(sae_pkg::CMD_READ);
      end else begin
        mode = $urandom_range(GEN_GROW, GEN_MIXED);
        for (int k = 0; k < 25; k++) push_random(pick_command(mode));
      end
      blk++;
    end

    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (commands_accepted != commands_total || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatches == 0) begin
      $display("[sortable_array_engine] OK");
    end else begin
      $display("[sortable_array_engine] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[sortable_array_engine] ERROR");
    $finish;
  end

endmodule
